// File: hdl/mcstt_pkg.sv
// shared types and constants of the multi-channel soft timer table
// no dependencies
package mcstt_pkg;

  localparam int TIMER_COUNT   = 16;
  localparam int INTERVAL_BITS = 16;
  localparam int MAX_RESULTS   = 16;

  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int NUM_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    ACT_SETUP    = 3'd0,
    ACT_CHANGE   = 3'd1,
    ACT_START    = 3'd2,
    ACT_TICK     = 3'd3,
    ACT_DISPATCH = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RMW  = 4'b0010,
    S_WALK = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  typedef struct packed {
    logic [INTERVAL_BITS-1:0] ival;
    logic [INTERVAL_BITS-1:0] cnt;
    logic                     run;
    logic                     single;
    logic                     handler;
    logic                     pending;
  } entry_t;

endpackage

// File: hdl/multi_channel_soft_timer_table.sv
// multi-channel soft timer table: timer entries in one synchronous memory
// depends on mcstt_pkg
//
//  channel | direction | handshake               | beat fields
//  --------+-----------+-------------------------+---------------------------------------------
//  in      | input     | in_valid_i / in_stall_o | action, timer_index, interval_value, flags
//  out     | output    | out_valid_o/out_stall_i | accepted, any_fired, dispatch_valid/index, last
//
// setup, change and start take one read and one write of the entry
// a rejected setup or an unknown code skips the entry access
// tick and dispatch walk the entry memory one entry a cycle while out stall does not hold the walk
// the entry memory has a single port pair; walk reads hit the entry being written only at the last entry
// reset clears control state and the per-entry valid bits, so all entries read as zero
// out stall holds the walk of a dispatch only when a further result is found while one is held
module multi_channel_soft_timer_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [3:0]  timer_index_i,
  input  logic [15:0] interval_value_i,
  input  logic        handler_present_i,
  input  logic        start_run_i,
  input  logic        start_single_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic        any_fired_o,
  output logic        dispatch_valid_o,
  output logic [3:0]  dispatch_index_o,
  output logic        last_o
);
  import mcstt_pkg::*;

  state_e                   state_q, state_d;
  logic [2:0]               act_q;
  logic [IDX_W-1:0]         idx_q;
  logic [INTERVAL_BITS-1:0] ival_q;
  logic                     srun_q, ssingle_q;
  logic                     res_acc_q;
  logic                     fired_q;
  logic                     held_v_q;
  logic [3:0]               held_idx_q;
  logic [NUM_W-1:0]         n_q;
  logic [IDX_W-1:0]         wk_q;

  entry_t                   mem_q [TIMER_COUNT];
  logic [TIMER_COUNT-1:0]   vld_q;
  entry_t                   rd_q;
  logic                     rd_vld_q;

  logic                     out_valid_q;
  logic                     out_acc_q, out_fired_q, out_dv_q, out_last_q;
  logic [3:0]               out_idx_q;

  logic                     in_acc, out_free, in_range, wk_last;
  logic [IDX_W-1:0]         in_idx, rd_addr, wr_addr;
  entry_t                   ent, walk_ent, rmw_ent, wr_data;
  logic                     hit, fire, advance, emit, load_resp, mem_we;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_idx     = IDX_W'(timer_index_i);
  assign in_range   = (32'(timer_index_i) < TIMER_COUNT);
  assign wk_last    = (wk_q == IDX_W'(TIMER_COUNT - 1));
  assign ent        = rd_vld_q ? rd_q : '0;

  always_comb begin
    walk_ent = ent;
    hit      = 1'b0;
    fire     = 1'b0;
    if (act_q == ACT_TICK) begin
      if (ent.run) begin
        if (ent.cnt == '0) begin
          walk_ent.pending = 1'b1;
          walk_ent.run     = ~ent.single;
          walk_ent.cnt     = ent.ival;
          fire             = 1'b1;
        end else begin
          walk_ent.cnt = ent.cnt - 1'b1;
        end
      end
    end else if (ent.pending) begin
      if (!ent.handler) begin
        walk_ent.pending = 1'b0;
      end else if (n_q < NUM_W'(MAX_RESULTS)) begin
        walk_ent.pending = 1'b0;
        hit              = 1'b1;
      end
    end
  end

  always_comb begin
    rmw_ent = ent;
    case (act_q)
      ACT_SETUP: begin
        rmw_ent.ival    = ival_q;
        rmw_ent.handler = 1'b1;
      end
      ACT_CHANGE: rmw_ent.ival = ival_q;
      ACT_START: begin
        rmw_ent.cnt    = ent.ival;
        rmw_ent.run    = srun_q;
        rmw_ent.single = ssingle_q;
      end
      default: rmw_ent = ent;
    endcase
  end

  assign advance   = (state_q == S_WALK) && !(hit && held_v_q && !out_free);
  assign emit      = (state_q == S_WALK) && hit && held_v_q && out_free;
  assign load_resp = (state_q == S_RESP) && out_free;
  assign mem_we    = advance || (state_q == S_RMW);
  assign wr_addr   = (state_q == S_WALK) ? wk_q : idx_q;
  assign wr_data   = (state_q == S_WALK) ? walk_ent : rmw_ent;

  always_comb begin
    rd_addr = in_idx;
    if (state_q == S_WALK) begin
      rd_addr = (advance && !wk_last) ? wk_q + 1'b1 : wk_q;
    end else if (action_i == ACT_TICK || action_i == ACT_DISPATCH) begin
      rd_addr = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (action_i)
            ACT_SETUP:    state_d = (handler_present_i && in_range) ? S_RMW : S_RESP;
            ACT_CHANGE,
            ACT_START:    state_d = in_range ? S_RMW : S_RESP;
            ACT_TICK,
            ACT_DISPATCH: state_d = S_WALK;
            default:      state_d = S_RESP;
          endcase
        end
      end
      S_RMW:  state_d = S_RESP;
      S_WALK: if (advance && wk_last) state_d = S_RESP;
      S_RESP: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_acc_q   <= 1'b1;
      fired_q     <= 1'b0;
      held_v_q    <= 1'b0;
      held_idx_q  <= '0;
      n_q         <= '0;
      wk_q        <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (out_valid_q && out_stall_i) || emit || load_resp;
      if (mem_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (in_acc) begin
        res_acc_q  <= !(action_i == ACT_SETUP && !handler_present_i);
        fired_q    <= 1'b0;
        held_v_q   <= 1'b0;
        held_idx_q <= '0;
        n_q        <= '0;
        wk_q       <= '0;
      end else if (advance) begin
        if (fire) fired_q <= 1'b1;
        if (hit) begin
          held_v_q   <= 1'b1;
          held_idx_q <= 4'(wk_q);
          n_q        <= n_q + 1'b1;
        end
        if (!wk_last) wk_q <= wk_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q     <= action_i;
      idx_q     <= in_idx;
      ival_q    <= INTERVAL_BITS'(interval_value_i);
      srun_q    <= start_run_i;
      ssingle_q <= start_single_i;
    end
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q     <= mem_q[rd_addr];
    rd_vld_q <= vld_q[rd_addr];
    if (emit) begin
      out_acc_q   <= 1'b1;
      out_fired_q <= 1'b0;
      out_dv_q    <= 1'b1;
      out_idx_q   <= held_idx_q;
      out_last_q  <= 1'b0;
    end else if (load_resp) begin
      out_acc_q   <= res_acc_q;
      out_fired_q <= fired_q;
      out_dv_q    <= held_v_q;
      out_idx_q   <= held_idx_q;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = out_acc_q;
  assign any_fired_o      = out_fired_q;
  assign dispatch_valid_o = out_dv_q;
  assign dispatch_index_o = out_idx_q;
  assign last_o           = out_last_q;

  a_dispatch_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dispatch_valid_o |-> accepted_o && !any_fired_o)
    else $error("dispatch beat with accepted low or fired set");

  a_fired_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && any_fired_o |-> last_o)
    else $error("tick beat not marked last");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_RMW || state_q == S_WALK))
    else $error("entry write outside rmw or walk");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NUM_W'(MAX_RESULTS))
    else $error("dispatch result count overflow");

endmodule

// File: tb/sv/tb_multi_channel_soft_timer_table.sv
// self-checking bench for multi_channel_soft_timer_table: directed table, then random commands
// a shadow copy of the timer table predicts the untyped reply beats; depends on mcstt_pkg and the rtl
module tb_multi_channel_soft_timer_table;
  timeunit 1ns;
  timeprecision 1ps;
  import mcstt_pkg::*;

  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          DRAIN_CYCLES = 3 * (TIMER_COUNT + 2);
  localparam int          HOLD_CYCLES  = 300;
  localparam int          PHASE_ITEMS  = 120;
  localparam logic [2:0]  ACT_RSVD_LO  = 3'd5;
  localparam logic [2:0]  ACT_RSVD_MID = 3'd6;
  localparam logic [2:0]  ACT_RSVD_HI  = 3'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  idx;
    logic [15:0] ival;
    logic        hnd;
    logic        srun;
    logic        ssingle;
  } timer_cmd_t;

  typedef struct packed {
    logic       accepted;
    logic       any_fired;
    logic       dispatch_valid;
    logic [3:0] dispatch_index;
    logic       last;
  } reply_t;

  typedef struct packed {
    timer_cmd_t cmd;
    logic       typed;
    reply_t     want;
  } dir_row_t;

  localparam reply_t R_DONE   = '{1'b1, 1'b0, 1'b0, 4'd0, 1'b1};
  localparam reply_t R_REJECT = '{1'b0, 1'b0, 1'b0, 4'd0, 1'b1};
  localparam reply_t R_PRED   = '0;

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{ACT_DISPATCH, 4'd0,  16'h0000, 1'b0, 1'b0, 1'b0}, 1'b1, R_DONE},
    '{'{ACT_TICK,     4'd0,  16'h0000, 1'b0, 1'b0, 1'b0}, 1'b1, R_DONE},
    '{'{ACT_SETUP,    4'd0,  16'hffff, 1'b0, 1'b1, 1'b1}, 1'b1, R_REJECT},
    '{'{ACT_SETUP,    4'd0,  16'h0000, 1'b1, 1'b0, 1'b0}, 1'b1, R_DONE},
    '{'{ACT_SETUP,    4'd15, 16'hffff, 1'b1, 1'b0, 1'b0}, 1'b1, R_DONE},
    '{'{ACT_CHANGE,   4'd15, 16'h0001, 1'b0, 1'b0, 1'b0}, 1'b1, R_DONE},
    '{'{ACT_SETUP,    4'd7,  16'h0000, 1'b1, 1'b0, 1'b0}, 1'b1, R_DONE},
    '{'{ACT_SETUP,    4'd7,  16'h0005, 1'b0, 1'b0, 1'b0}, 1'b1, R_REJECT},
    '{'{ACT_START,    4'd0,  16'h0000, 1'b0, 1'b1, 1'b1}, 1'b1, R_DONE},
    '{'{ACT_START,    4'd15, 16'h0000, 1'b0, 1'b1, 1'b0}, 1'b1, R_DONE},
    '{'{ACT_START,    4'd3,  16'h0000, 1'b0, 1'b1, 1'b0}, 1'b1, R_DONE},
    '{'{ACT_START,    4'd7,  16'h0000, 1'b0, 1'b1, 1'b0}, 1'b1, R_DONE},
    '{'{ACT_TICK,     4'd0,  16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, R_PRED},
    '{'{ACT_TICK,     4'd0,  16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, R_PRED},
    '{'{ACT_DISPATCH, 4'd0,  16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, R_PRED},
    '{'{ACT_DISPATCH, 4'd0,  16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, R_PRED},
    '{'{ACT_RSVD_LO,  4'd15, 16'hffff, 1'b1, 1'b1, 1'b1}, 1'b1, R_DONE},
    '{'{ACT_RSVD_MID, 4'd15, 16'hffff, 1'b1, 1'b1, 1'b1}, 1'b1, R_DONE},
    '{'{ACT_RSVD_HI,  4'd0,  16'h0000, 1'b0, 1'b0, 1'b0}, 1'b1, R_DONE},
    '{'{ACT_START,    4'd7,  16'h0000, 1'b0, 1'b0, 1'b1}, 1'b1, R_DONE},
    '{'{ACT_CHANGE,   4'd0,  16'hffff, 1'b0, 1'b0, 1'b0}, 1'b1, R_DONE},
    '{'{ACT_TICK,     4'd0,  16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, R_PRED},
    '{'{ACT_TICK,     4'd0,  16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, R_PRED},
    '{'{ACT_DISPATCH, 4'd0,  16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, R_PRED}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  action_i;
  logic [3:0]  timer_index_i;
  logic [15:0] interval_value_i;
  logic        handler_present_i;
  logic        start_run_i;
  logic        start_single_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        accepted_o;
  logic        any_fired_o;
  logic        dispatch_valid_o;
  logic [3:0]  dispatch_index_o;
  logic        last_o;

  logic [INTERVAL_BITS-1:0] tt_ival    [TIMER_COUNT];
  logic [INTERVAL_BITS-1:0] tt_count   [TIMER_COUNT];
  logic                     tt_run     [TIMER_COUNT];
  logic                     tt_single  [TIMER_COUNT];
  logic                     tt_handler [TIMER_COUNT];
  logic                     tt_pending [TIMER_COUNT];

  reply_t      due_replies [$];
  int unsigned err_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  bit          hold_ack;
  int unsigned hold_left;

  multi_channel_soft_timer_table i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .timer_index_i     (timer_index_i),
    .interval_value_i  (interval_value_i),
    .handler_present_i (handler_present_i),
    .start_run_i       (start_run_i),
    .start_single_i    (start_single_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .accepted_o        (accepted_o),
    .any_fired_o       (any_fired_o),
    .dispatch_valid_o  (dispatch_valid_o),
    .dispatch_index_o  (dispatch_index_o),
    .last_o            (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // shadow of the timer table, applies one command and queues its reply beats when keep is set
  function automatic void shadow_table_apply(input timer_cmd_t c, input bit keep);
    reply_t r;
    bit     fired;
    int     hits [$];
    r = R_DONE;
    case (c.action)
      ACT_SETUP: begin
        if (!c.hnd) begin
          r.accepted = 1'b0;
        end else begin
          tt_ival[c.idx]    = c.ival;
          tt_handler[c.idx] = 1'b1;
        end
      end
      ACT_CHANGE: tt_ival[c.idx] = c.ival;
      ACT_START: begin
        tt_count[c.idx]  = tt_ival[c.idx];
        tt_run[c.idx]    = c.srun;
        tt_single[c.idx] = c.ssingle;
      end
      ACT_TICK: begin
        fired = 1'b0;
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (tt_run[i]) begin
            if (tt_count[i] == '0) begin
              tt_pending[i] = 1'b1;
              fired = 1'b1;
              if (tt_single[i]) tt_run[i] = 1'b0;
              tt_count[i] = tt_ival[i];
            end else begin
              tt_count[i] = tt_count[i] - 1'b1;
            end
          end
        end
        r.any_fired = fired;
      end
      ACT_DISPATCH: begin
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (tt_pending[i]) begin
            if (!tt_handler[i]) begin
              tt_pending[i] = 1'b0;
            end else if (hits.size() < MAX_RESULTS) begin
              tt_pending[i] = 1'b0;
              hits.push_back(i);
            end
          end
        end
      end
      default: ;
    endcase
    if (!keep) return;
    if (hits.size() == 0) begin
      due_replies.push_back(r);
    end else begin
      foreach (hits[k]) begin
        r = '{1'b1, 1'b0, 1'b1, 4'(hits[k]), 1'b0};
        r.last = (k == hits.size() - 1);
        due_replies.push_back(r);
      end
    end
  endfunction

  function automatic timer_cmd_t pick_cmd();
    timer_cmd_t  c;
    int unsigned w;
    w         = $urandom_range(0, 99);
    c.idx     = 4'($urandom_range(0, TIMER_COUNT - 1));
    c.ival    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    c.hnd     = ($urandom_range(0, 5) != 0);
    c.srun    = ($urandom_range(0, 4) != 0);
    c.ssingle = ($urandom_range(0, 2) == 0);
    if (w < 12)      c.action = ACT_SETUP;
    else if (w < 20) c.action = ACT_CHANGE;
    else if (w < 38) c.action = ACT_START;
    else if (w < 78) c.action = ACT_TICK;
    else if (w < 95) c.action = ACT_DISPATCH;
    else             c.action = 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
    return c;
  endfunction

  task automatic send_cmd(input timer_cmd_t c, input bit typed, input reply_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    action_i          = c.action;
    timer_index_i     = c.idx;
    interval_value_i  = c.ival;
    handler_present_i = c.hnd;
    start_run_i       = c.srun;
    start_single_i    = c.ssingle;
    do @(posedge clk_i); while (in_stall_o);
    shadow_table_apply(c, !typed);
    if (typed) due_replies.push_back(want);
    @(negedge clk_i);
  endtask

  // receiver: random stall plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    hold_ack    = 1'b0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_ack) begin
        hold_left = HOLD_CYCLES;
        hold_ack  = hold_req;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_replies.size() == 0) begin
        $error("unexpected reply beat: dispatch_index %0d", dispatch_index_o);
        err_count++;
      end else begin
        want = due_replies.pop_front();
        if (accepted_o !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, accepted_o);
          err_count++;
        end
        if (any_fired_o !== want.any_fired) begin
          $error("any_fired: expected %0d, got %0d", want.any_fired, any_fired_o);
          err_count++;
        end
        if (dispatch_valid_o !== want.dispatch_valid) begin
          $error("dispatch_valid: expected %0d, got %0d", want.dispatch_valid,
                 dispatch_valid_o);
          err_count++;
        end
        if (dispatch_index_o !== want.dispatch_index) begin
          $error("dispatch_index: expected %0d, got %0d", want.dispatch_index,
                 dispatch_index_o);
          err_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          err_count++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_multi_channel_soft_timer_table: done, errors");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    action_i          = ACT_SETUP;
    timer_index_i     = '0;
    interval_value_i  = '0;
    handler_present_i = 1'b0;
    start_run_i       = 1'b0;
    start_single_i    = 1'b0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    hold_req          = 1'b0;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      tt_ival[i]    = '0;
      tt_count[i]   = '0;
      tt_run[i]     = 1'b0;
      tt_single[i]  = 1'b0;
      tt_handler[i] = 1'b0;
      tt_pending[i] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_cmd(DIR_TAB[r].cmd, DIR_TAB[r].typed, DIR_TAB[r].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 37 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 40) hold_req = ~hold_req;
        if (ph == 1 && n == 60) begin
          in_valid_i = 1'b0;
          while (due_replies.size() != 0) @(negedge clk_i);
        end
        send_cmd(pick_cmd(), 1'b0, R_PRED);
      end
    end
    in_valid_i = 1'b0;

    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_multi_channel_soft_timer_table: done, clean");
    end else begin
      $display("tb_multi_channel_soft_timer_table: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/mcstt_pkg.sv
hdl/multi_channel_soft_timer_table.sv
tb/sv/tb_multi_channel_soft_timer_table.sv
